// ----- hw/rtl/wbps_pkg.sv -----
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner package
// Shared constants, register codes and the queued item type.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

    localparam int unsigned CFG_DATA_W     = 64;
    localparam int unsigned CFG_ADDR_W     = 5;
    localparam int unsigned PLEN_W         = 5;
    localparam int unsigned MATCH_OFFSET_W = 32;
    localparam int unsigned REG_INDEX_W    = 2;

    localparam logic [7:0] WILDCARD_BYTE = 8'hFF;

    typedef enum logic [REG_INDEX_W-1:0] {
        REG_PATTERN_LOW  = 2'd0,
        REG_PATTERN_HIGH = 2'd1,
        REG_PATTERN_LEN  = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } scan_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wbps_in_if.sv -----
// ----------------------------------------------------------------------------
// Scanner input channel
// Valid/ready channel that carries one byte of the scanned region.
// ----------------------------------------------------------------------------
`default_nettype none

interface wbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output first_byte,
                    output last_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input last_byte, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/wbps_out_if.sv -----
// ----------------------------------------------------------------------------
// Scanner result channel
// Valid/ready channel that carries the match result of one region.
// ----------------------------------------------------------------------------
`default_nettype none

interface wbps_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/wbps_regs.sv -----
// ----------------------------------------------------------------------------
// Scanner configuration registers
// APB register file for the pattern and its length, and the derived
// effective pattern length.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_regs #(
    parameter int unsigned MAX_PATTERN_BYTES = 16,
    parameter int unsigned LEN_W             = 5
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [wbps_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [wbps_pkg::CFG_DATA_W-1:0]   prdata,
    output logic      [MAX_PATTERN_BYTES*8-1:0]    pattern,
    output logic      [LEN_W-1:0]                  eff_len
);
    import wbps_pkg::*;

    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [PLEN_W-1:0]     plen_reg;
    logic [2*CFG_DATA_W-1:0] pat_all;
    reg_index_t            reg_index;
    logic                  wr_en;

    assign reg_index = reg_index_t'(paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_INDEX_W]);
    assign wr_en     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            plen_reg     <= '0;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_PATTERN_LOW:  pat_low_reg  <= pwdata;
                REG_PATTERN_HIGH: pat_high_reg <= pwdata;
                REG_PATTERN_LEN:  plen_reg     <= pwdata[PLEN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_PATTERN_LOW:  prdata = pat_low_reg;
            REG_PATTERN_HIGH: prdata = pat_high_reg;
            REG_PATTERN_LEN:  prdata = {{(CFG_DATA_W-PLEN_W){1'b0}}, plen_reg};
            default:          prdata = '0;
        endcase
    end

    assign pat_all = {pat_high_reg, pat_low_reg};
    assign pattern = pat_all[MAX_PATTERN_BYTES*8-1:0];

    // A zero length register means the pattern ends at its first zero byte.
    always_comb
    begin
        logic stop;
        stop    = 1'b0;
        eff_len = LEN_W'(MAX_PATTERN_BYTES);
        if (plen_reg != '0)
        begin
            if (plen_reg <= PLEN_W'(MAX_PATTERN_BYTES))
            begin
                eff_len = LEN_W'(plen_reg);
            end
        end
        else
        begin
            for (int k = 0; k < MAX_PATTERN_BYTES; k++)
            begin
                if (!stop && pattern[8*k +: 8] == 8'h00)
                begin
                    eff_len = LEN_W'(k);
                    stop    = 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/wbps_front.sv -----
// ----------------------------------------------------------------------------
// Scanner front end
// Accepts input bytes and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    wbps_in_if.sink                   scan_in,
    output logic                      q_valid,
    output wbps_pkg::scan_item_t      q_item,
    input  wire logic                 q_pop
);
    import wbps_pkg::*;

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    scan_item_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    scan_item_t       in_item;

    assign scan_in.ready = (count_reg != CNT_W'(DEPTH));
    assign push          = scan_in.valid && scan_in.ready;
    assign in_item       = '{data_byte:  scan_in.data_byte,
                             first_byte: scan_in.first_byte,
                             last_byte:  scan_in.last_byte};

    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (!push && q_pop)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/wbps_back.sv -----
// ----------------------------------------------------------------------------
// Scanner back end
// Shifts bytes into the window, compares it with the pattern and
// registers the result of each region.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_back #(
    parameter int unsigned MAX_PATTERN_BYTES = 16,
    parameter int unsigned OFFSET_BITS       = 32,
    parameter int unsigned LEN_W             = 5
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            q_valid,
    input  wire wbps_pkg::scan_item_t            q_item,
    output logic                                 q_pop,
    input  wire logic [MAX_PATTERN_BYTES*8-1:0]  pattern,
    input  wire logic [LEN_W-1:0]                eff_len,
    wbps_out_if.source                           scan_out
);
    import wbps_pkg::*;

    localparam int unsigned IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    logic [7:0]             win_reg  [MAX_PATTERN_BYTES];
    logic [7:0]             win_next [MAX_PATTERN_BYTES];
    logic [OFFSET_BITS-1:0] seen_reg;
    logic                   match_reg;
    logic [OFFSET_BITS-1:0] first_off_reg;
    logic                   out_valid_reg;
    logic                   out_found_reg;
    logic [MATCH_OFFSET_W-1:0] out_offset_reg;

    logic [OFFSET_BITS-1:0] seen_base;
    logic [OFFSET_BITS-1:0] seen_next;
    logic                   match_base;
    logic [OFFSET_BITS-1:0] off_base;
    logic                   window_hit;
    logic                   take_hit;
    logic                   match_next;
    logic [OFFSET_BITS-1:0] off_next;

    // A region end needs the result register free; other bytes never wait.
    assign q_pop = q_valid && (!q_item.last_byte || !out_valid_reg || scan_out.ready);

    always_comb
    begin
        for (int i = MAX_PATTERN_BYTES - 1; i > 0; i--)
        begin
            win_next[i] = win_reg[i-1];
        end
        win_next[0] = q_item.data_byte;
    end

    // Pattern byte i lines up with window entry eff_len-1-i.
    always_comb
    begin
        logic [LEN_W-1:0] idx;
        logic [7:0]       pbyte;
        logic [7:0]       wbyte;
        window_hit = 1'b1;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
        begin
            idx   = eff_len - LEN_W'(i) - LEN_W'(1);
            pbyte = pattern[8*i +: 8];
            wbyte = win_next[idx[IDX_W-1:0]];
            if (LEN_W'(i) < eff_len && pbyte != WILDCARD_BYTE && pbyte != wbyte)
            begin
                window_hit = 1'b0;
            end
        end
    end

    always_comb
    begin
        seen_base  = q_item.first_byte ? '0 : seen_reg;
        match_base = q_item.first_byte ? 1'b0 : match_reg;
        off_base   = q_item.first_byte ? '0 : first_off_reg;
        seen_next  = (seen_base == '1) ? seen_base : seen_base + OFFSET_BITS'(1);
        take_hit   = (eff_len != '0) && !match_base
                     && (seen_next >= OFFSET_BITS'(eff_len)) && window_hit;
        match_next = match_base || take_hit;
        off_next   = take_hit ? (seen_next - OFFSET_BITS'(eff_len)) : off_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PATTERN_BYTES; i++)
            begin
                win_reg[i] <= '0;
            end
            seen_reg       <= '0;
            match_reg      <= 1'b0;
            first_off_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_found_reg  <= 1'b0;
            out_offset_reg <= '0;
        end
        else
        begin
            if (q_pop && q_item.last_byte)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (scan_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop)
            begin
                win_reg <= win_next;
                if (q_item.last_byte)
                begin
                    seen_reg       <= '0;
                    match_reg      <= 1'b0;
                    first_off_reg  <= '0;
                    out_found_reg  <= match_next;
                    out_offset_reg <= match_next ? MATCH_OFFSET_W'(off_next) : '0;
                end
                else
                begin
                    seen_reg      <= seen_next;
                    match_reg     <= match_next;
                    first_off_reg <= off_next;
                end
            end
        end
    end

    assign scan_out.valid        = out_valid_reg;
    assign scan_out.found        = out_found_reg;
    assign scan_out.match_offset = out_offset_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/wildcard_byte_pattern_scanner.sv -----
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner
// Scans a byte stream for a pattern with 0xFF wildcards and reports the
// first match of each region.
// ----------------------------------------------------------------------------
// The scanner takes one byte per clock cycle and keeps that rate for as long
// as results are taken. A byte enters a four-entry queue; the back end takes
// one byte per cycle from it, shifts it into the window and compares the
// whole window with the pattern in that same cycle, so the window compare
// sets the rate. When the last byte of a region leaves the queue, the result
// is registered in an output register and waits there; a waiting result
// stalls only the next region end, not the bytes in front of it.
// Program the pattern through the APB port while no region is in flight.
`default_nettype none

module wildcard_byte_pattern_scanner #(
    parameter int unsigned MAX_PATTERN_BYTES = 16,
    parameter int unsigned OFFSET_BITS       = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [wbps_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [wbps_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready,
    wbps_in_if.sink                                scan_in,
    wbps_out_if.source                             scan_out
);
    import wbps_pkg::*;

    localparam int unsigned LEN_W = $clog2(MAX_PATTERN_BYTES + 1);

    logic [MAX_PATTERN_BYTES*8-1:0] pattern;
    logic [LEN_W-1:0]               eff_len;
    logic                           q_valid;
    scan_item_t                     q_item;
    logic                           q_pop;

    assign pready = 1'b1;

    wbps_regs #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .LEN_W             (LEN_W)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pattern (pattern),
        .eff_len (eff_len)
    );

    wbps_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .scan_in (scan_in),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    wbps_back #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .OFFSET_BITS       (OFFSET_BITS),
        .LEN_W             (LEN_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .pattern  (pattern),
        .eff_len  (eff_len),
        .scan_out (scan_out)
    );

endmodule

`default_nettype wire

// ----- test/tb_wildcard_byte_pattern_scanner.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner testbench
// Streams byte regions through the scanner under a series of pattern and
// length settings. Both channels idle at random, and the result channel is
// held off once for a long stretch. Every region result is checked against
// a predictor of the scan that the testbench keeps for itself.
// ----------------------------------------------------------------------------

module tb_wildcard_byte_pattern_scanner;
    import wbps_pkg::*;

    localparam int PATTERN_BYTES = 16;
    localparam int PHASES        = 10;
    localparam int PHASE_BYTES   = 90;
    localparam int DRAIN_CYCLES  = 12;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 300000;

    typedef struct packed {
        logic                      found;
        logic [MATCH_OFFSET_W-1:0] match_offset;
    } scan_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    wbps_in_if  scan_in_bus ();
    wbps_out_if scan_out_bus ();

    wildcard_byte_pattern_scanner dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .scan_in  (scan_in_bus),
        .scan_out (scan_out_bus)
    );

    // Pattern registers as last written.
    logic [63:0]       pattern_low;
    logic [63:0]       pattern_high;
    logic [PLEN_W-1:0] pattern_len;

    // Predicted scan state.
    logic [7:0]  window_bytes [PATTERN_BYTES];
    logic [31:0] bytes_in_region;
    logic [31:0] first_hit_offset;
    bit          hit_seen;

    scan_item_t   pending_bytes [$];
    scan_result_t expected_results [$];

    int cycle_count;
    int error_count;
    int send_gap;
    int take_gap;
    int hold_span;
    bit in_fire;
    bit out_fire;
    bit no_idle;
    bit hold_req;
    bit out_hold;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] pattern_byte(int k);
        logic [127:0] all_bytes;
        all_bytes = {pattern_high, pattern_low};
        return all_bytes[8*k +: 8];
    endfunction

    // A zero length register means the pattern ends at its first zero byte.
    function automatic int pattern_span();
        if (pattern_len != 0)
            return (pattern_len > PATTERN_BYTES) ? PATTERN_BYTES : int'(pattern_len);
        for (int k = 0; k < PATTERN_BYTES; k++)
            if (pattern_byte(k) == 8'h00)
                return k;
        return PATTERN_BYTES;
    endfunction

    function automatic void restart_region();
        bytes_in_region  = '0;
        hit_seen         = 1'b0;
        first_hit_offset = '0;
    endfunction

    function automatic void predict_scan_byte(scan_item_t item);
        int           span;
        bit           hit;
        scan_result_t res;
        span = pattern_span();
        if (item.first_byte)
            restart_region();
        for (int i = PATTERN_BYTES - 1; i > 0; i--)
            window_bytes[i] = window_bytes[i-1];
        window_bytes[0] = item.data_byte;
        if (bytes_in_region != '1)
            bytes_in_region++;
        if (span != 0 && !hit_seen && bytes_in_region >= 32'(span))
        begin
            hit = 1'b1;
            for (int i = 0; i < span; i++)
                if (pattern_byte(i) != WILDCARD_BYTE && pattern_byte(i) != window_bytes[span-1-i])
                    hit = 1'b0;
            if (hit)
            begin
                hit_seen         = 1'b1;
                first_hit_offset = bytes_in_region - 32'(span);
            end
        end
        if (item.last_byte)
        begin
            res.found        = hit_seen;
            res.match_offset = hit_seen ? first_hit_offset : '0;
            expected_results.push_back(res);
            restart_region();
        end
    endfunction

    task automatic report_mismatch(string what);
        error_count++;
        $display("[%0t] scan result mismatch: %s", $realtime, what);
    endtask

    task automatic write_register(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_PATTERN_LOW:  pattern_low  = value;
            REG_PATTERN_HIGH: pattern_high = value;
            REG_PATTERN_LEN:  pattern_len  = value[PLEN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic queue_byte(logic [7:0] data, bit first, bit last);
        scan_item_t item;
        item.data_byte  = data;
        item.first_byte = first;
        item.last_byte  = last;
        pending_bytes.push_back(item);
    endtask

    // Bytes without a region end give no result, so allow the pipeline to empty.
    task automatic wait_drained();
        while (pending_bytes.size() != 0 || expected_results.size() != 0 || scan_in_bus.valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Input transactions are predicted before result transactions are checked.
    always @(posedge clk)
    begin
        scan_item_t   taken;
        scan_result_t want;
        in_fire  = rst_n && scan_in_bus.valid && scan_in_bus.ready;
        out_fire = rst_n && scan_out_bus.valid && scan_out_bus.ready;
        if (in_fire)
        begin
            taken.data_byte  = scan_in_bus.data_byte;
            taken.first_byte = scan_in_bus.first_byte;
            taken.last_byte  = scan_in_bus.last_byte;
            predict_scan_byte(taken);
        end
        if (out_fire)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected transaction, found=%0b offset=%0d",
                                          scan_out_bus.found, scan_out_bus.match_offset));
            else
            begin
                want = expected_results.pop_front();
                if (scan_out_bus.found !== want.found)
                    report_mismatch($sformatf("found=%0b, expected %0b",
                                              scan_out_bus.found, want.found));
                if (scan_out_bus.match_offset !== want.match_offset)
                    report_mismatch($sformatf("match_offset=%0d, expected %0d",
                                              scan_out_bus.match_offset, want.match_offset));
            end
        end
    end

    always @(negedge clk)
    begin
        scan_item_t item;
        if (!rst_n)
        begin
            scan_in_bus.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_fire)
                send_gap = no_idle ? 0 : $urandom_range(0, 9);
            if (scan_in_bus.valid && !in_fire)
                ;
            else if (send_gap > 0)
            begin
                send_gap--;
                scan_in_bus.valid <= 1'b0;
            end
            else if (pending_bytes.size() != 0)
            begin
                item = pending_bytes.pop_front();
                scan_in_bus.valid      <= 1'b1;
                scan_in_bus.data_byte  <= item.data_byte;
                scan_in_bus.first_byte <= item.first_byte;
                scan_in_bus.last_byte  <= item.last_byte;
            end
            else
                scan_in_bus.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            scan_out_bus.ready <= 1'b0;
            take_gap = 0;
        end
        else
        begin
            if (out_fire)
                take_gap = no_idle ? 0 : $urandom_range(0, 9);
            if (out_hold)
                scan_out_bus.ready <= 1'b0;
            else if (take_gap > 0)
            begin
                take_gap--;
                scan_out_bus.ready <= 1'b0;
            end
            else
                scan_out_bus.ready <= 1'b1;
        end
    end

    // One long hold-off of the result channel so that the scanner backs up.
    always @(negedge clk)
    begin
        if (hold_req && hold_span < HOLD_CYCLES)
        begin
            out_hold <= 1'b1;
            hold_span++;
        end
        else
            out_hold <= 1'b0;
    end

    initial
    begin
        int                span;
        int                region_len;
        int                at;
        int                queued;
        int                kind;
        int                pick;
        logic [127:0]      pat;
        logic [PLEN_W-1:0] len_code;
        logic [7:0]        region [$];
        scan_item_t        item;

        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        scan_in_bus.valid        = 1'b0;
        scan_in_bus.data_byte    = '0;
        scan_in_bus.first_byte   = 1'b0;
        scan_in_bus.last_byte    = 1'b0;
        scan_out_bus.ready       = 1'b0;
        pattern_low              = '0;
        pattern_high             = '0;
        pattern_len              = '0;
        for (int i = 0; i < PATTERN_BYTES; i++)
            window_bytes[i] = 8'h00;
        restart_region();

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Registers at their reset value give an empty pattern: nothing matches.
        queue_byte(8'h00, 1'b1, 1'b1);
        wait_drained();

        // Pattern AB ?? CD with an explicit length of three.
        write_register(REG_PATTERN_LOW, 64'h0000_0000_00CD_FFAB);
        write_register(REG_PATTERN_LEN, 64'd3);
        queue_byte(8'hAB, 1'b1, 1'b0);
        queue_byte(8'h77, 1'b0, 1'b0);
        queue_byte(8'hCD, 1'b0, 1'b1);
        // No start mark: the previous region end already restarted the count.
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'hAB, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'hCD, 1'b0, 1'b1);
        queue_byte(8'hAB, 1'b1, 1'b1);
        // A start mark inside a region restarts the offsets.
        queue_byte(8'h22, 1'b1, 1'b0);
        queue_byte(8'hAB, 1'b1, 1'b0);
        queue_byte(8'h99, 1'b0, 1'b0);
        queue_byte(8'hCD, 1'b0, 1'b1);
        queue_byte(8'hAB, 1'b1, 1'b0);
        queue_byte(8'hCD, 1'b0, 1'b1);
        wait_drained();

        // Zero length: the pattern is 5A ?? and stops at the zero byte.
        write_register(REG_PATTERN_LOW, 64'h0000_0000_0000_FF5A);
        write_register(REG_PATTERN_LEN, 64'd0);
        queue_byte(8'h5A, 1'b1, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b1);
        queue_byte(8'hFF, 1'b1, 1'b0);
        queue_byte(8'h5A, 1'b0, 1'b1);
        wait_drained();

        // With an explicit length, zero pattern bytes are literal.
        write_register(REG_PATTERN_LOW, 64'd0);
        write_register(REG_PATTERN_LEN, 64'd2);
        queue_byte(8'h00, 1'b1, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b1);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            kind = (phase < 7) ? phase : $urandom_range(0, 6);
            pat  = {$urandom, $urandom, $urandom, $urandom};
            for (int k = 0; k < PATTERN_BYTES; k++)
                if ($urandom_range(0, 3) == 0)
                    pat[8*k +: 8] = WILDCARD_BYTE;
            case (kind)
                0: len_code = (phase == 0) ? PLEN_W'(16) : PLEN_W'($urandom_range(1, 16));
                1:
                begin
                    len_code = '0;
                    pick = $urandom_range(0, PATTERN_BYTES - 1);
                    pat[8*pick +: 8] = 8'h00;
                end
                2:
                begin
                    len_code = '0;
                    for (int k = 0; k < PATTERN_BYTES; k++)
                        if (pat[8*k +: 8] == 8'h00)
                            pat[8*k +: 8] = 8'h01;
                end
                3: len_code = PLEN_W'($urandom_range(17, 31));
                4:
                begin
                    pat      = '1;
                    len_code = '1;
                end
                5:
                begin
                    len_code = PLEN_W'($urandom_range(1, 16));
                    for (int k = 0; k < PATTERN_BYTES; k++)
                        if ($urandom_range(0, 2) == 0)
                            pat[8*k +: 8] = 8'h00;
                end
                default:
                begin
                    pat      = '0;
                    len_code = '0;
                end
            endcase
            write_register(REG_PATTERN_LOW, pat[63:0]);
            write_register(REG_PATTERN_HIGH, pat[127:64]);
            write_register(REG_PATTERN_LEN, CFG_DATA_W'(len_code));

            no_idle = (phase % 4 == 3);
            if (phase == 1)
                hold_req = 1'b1;
            span   = pattern_span();
            queued = 0;
            while (queued < PHASE_BYTES)
            begin
                if (phase == 1)
                    region_len = $urandom_range(1, span + 2);
                else if ($urandom_range(0, 9) == 0)
                    region_len = $urandom_range(30, 120);
                else
                    region_len = $urandom_range(1, span + 12);
                // Filler leans on pattern bytes so that partial matches are common.
                region.delete();
                for (int i = 0; i < region_len; i++)
                    if (span == 0 || $urandom_range(0, 2) == 0)
                        region.push_back(8'($urandom));
                    else
                        region.push_back(pattern_byte($urandom_range(0, span - 1)));
                if (span != 0 && region_len >= span && $urandom_range(0, 9) < 6)
                begin
                    at = $urandom_range(0, region_len - span);
                    for (int k = 0; k < span; k++)
                        if (pattern_byte(k) != WILDCARD_BYTE)
                            region[at+k] = pattern_byte(k);
                end
                for (int i = 0; i < region_len; i++)
                begin
                    item.data_byte  = region[i];
                    item.first_byte = (i == 0) ? ($urandom_range(0, 9) != 0)
                                               : ($urandom_range(0, 60) == 0);
                    item.last_byte  = (i == region_len - 1);
                    pending_bytes.push_back(item);
                end
                queued += region_len;
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
